// ===== rtl/bdg_pkg.sv =====
// box drawing glyph generator: shared types, part masks and glyph table
// no dependencies
package bdg_pkg;

  localparam int GEO_W = 7;   // covers cell sizes up to 64 plus the bar offsets
  localparam int CFG_W = 6;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic REG_CELL_WIDTH  = 1'b0;
  localparam logic REG_CELL_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] RST_CELL_WIDTH  = 6'd8;
  localparam logic [CFG_W-1:0] RST_CELL_HEIGHT = 6'd16;

  localparam logic [7:0] FIRST_CODE = 8'd179;
  localparam logic [7:0] LAST_CODE  = 8'd223;
  localparam int NUM_GLYPHS = 45;

  typedef logic [24:0] part_mask_t;

  localparam part_mask_t M_FULL = part_mask_t'(1) << 0;
  localparam part_mask_t M_TOP  = part_mask_t'(1) << 1;
  localparam part_mask_t M_BOT  = part_mask_t'(1) << 2;
  localparam part_mask_t M_LH   = part_mask_t'(1) << 3;
  localparam part_mask_t M_RH   = part_mask_t'(1) << 4;
  localparam part_mask_t M_V1   = part_mask_t'(1) << 5;
  localparam part_mask_t M_V2   = part_mask_t'(1) << 6;
  localparam part_mask_t M_L1S  = part_mask_t'(1) << 7;
  localparam part_mask_t M_L1L  = part_mask_t'(1) << 8;
  localparam part_mask_t M_L2S  = part_mask_t'(1) << 9;
  localparam part_mask_t M_L2L  = part_mask_t'(1) << 10;
  localparam part_mask_t M_R1S  = part_mask_t'(1) << 11;
  localparam part_mask_t M_R1L  = part_mask_t'(1) << 12;
  localparam part_mask_t M_R2S  = part_mask_t'(1) << 13;
  localparam part_mask_t M_R2L  = part_mask_t'(1) << 14;
  localparam part_mask_t M_H1   = part_mask_t'(1) << 15;
  localparam part_mask_t M_H2   = part_mask_t'(1) << 16;
  localparam part_mask_t M_U1L  = part_mask_t'(1) << 17;
  localparam part_mask_t M_U1S  = part_mask_t'(1) << 18;
  localparam part_mask_t M_U2L  = part_mask_t'(1) << 19;
  localparam part_mask_t M_U2S  = part_mask_t'(1) << 20;
  localparam part_mask_t M_D1L  = part_mask_t'(1) << 21;
  localparam part_mask_t M_D1S  = part_mask_t'(1) << 22;
  localparam part_mask_t M_D2L  = part_mask_t'(1) << 23;
  localparam part_mask_t M_D2S  = part_mask_t'(1) << 24;

  // parts lit for each code, first entry is the first handled code
  localparam part_mask_t GLYPH_PARTS [0:NUM_GLYPHS-1] = '{
    M_V1,
    M_V1 | M_L1S,
    M_V1 | M_L1S | M_L2S,
    M_V1 | M_V2 | M_L1S,
    M_L1L | M_D1S | M_D2S,
    M_L1S | M_L2S | M_D1L,
    M_V1 | M_V2 | M_L1S | M_L2S,
    M_V1 | M_V2,
    M_L1S | M_L2L | M_D1S | M_D2L,
    M_L1L | M_L2S | M_U1S | M_U2L,
    M_L1L | M_U1L | M_U2L,
    M_L1S | M_L2S | M_U1L,
    M_L1S | M_D1S,
    M_R1L | M_U1L,
    M_H1 | M_U1L,
    M_H1 | M_D1S,
    M_V1 | M_R1L,
    M_H1,
    M_V1 | M_H1,
    M_V1 | M_R1L | M_R2L,
    M_V1 | M_V2 | M_R1S,
    M_R1L | M_R2S | M_U1L | M_U2S,
    M_R1S | M_R2L | M_D1L | M_D2S,
    M_L2S | M_R2S | M_H1 | M_U1S | M_U2S,
    M_L1S | M_R1S | M_H2 | M_D1S | M_D2S,
    M_V1 | M_R1S | M_R2S | M_U2S | M_D2S,
    M_H1 | M_H2,
    M_V1 | M_V2 | M_L1S | M_L2S | M_R1S | M_R2S | M_U1S | M_U2S | M_D1S | M_D2S,
    M_H1 | M_H2 | M_U1S,
    M_L1L | M_U1L | M_U2L | M_H1,
    M_H1 | M_H2 | M_D1S,
    M_L1L | M_D1S | M_D2S | M_H1,
    M_R1L | M_U1L | M_U2L,
    M_R1L | M_R2L | M_U1L,
    M_R1L | M_R2L | M_D1L,
    M_R1L | M_D1S | M_D2S,
    M_V1 | M_V2 | M_L1S | M_H1,
    M_V1 | M_H1 | M_H2,
    M_L1S | M_U1L,
    M_R1L | M_D1S,
    M_FULL,
    M_BOT,
    M_LH,
    M_RH,
    M_TOP
  };

  // cell geometry, derived from the configured size
  typedef struct packed {
    logic [GEO_W-1:0] fw;
    logic [GEO_W-1:0] fh;
    logic [GEO_W-1:0] latx;
    logic [GEO_W-1:0] ratx;
    logic [GEO_W-1:0] taty;
    logic [GEO_W-1:0] baty;
  } geo_t;

  typedef struct packed {
    logic pixel_on;
    logic handled;
  } pix_res_t;

endpackage

// ===== rtl/bdg_cfg_regs.sv =====
// box drawing glyph generator: cell size registers on the apb port and bar geometry
// depends on bdg_pkg
module bdg_cfg_regs #(
  parameter int MAX_CELL_WIDTH  = 32,
  parameter int MAX_CELL_HEIGHT = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bdg_pkg::ADDR_W-1:0]   paddr,
  input  logic [bdg_pkg::DATA_W-1:0]   pwdata,
  output logic [bdg_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output bdg_pkg::geo_t                geo_o
);
  import bdg_pkg::*;

  localparam int FwW = $clog2(MAX_CELL_WIDTH + 1);
  localparam int FhW = $clog2(MAX_CELL_HEIGHT + 1);

  logic [CFG_W-1:0] cell_width_q, cell_height_q;
  logic             wr_en;
  logic [FwW-1:0]   fw;
  logic [FhW-1:0]   fh;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_width_q  <= RST_CELL_WIDTH;
      cell_height_q <= RST_CELL_HEIGHT;
    end else if (wr_en) begin
      case (paddr[2])
        REG_CELL_WIDTH:  cell_width_q  <= pwdata[CFG_W-1:0];
        REG_CELL_HEIGHT: cell_height_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CELL_WIDTH:  prdata = DATA_W'(cell_width_q);
      REG_CELL_HEIGHT: prdata = DATA_W'(cell_height_q);
      default:         prdata = '0;
    endcase
  end

  // saturate at the largest cell
  always_comb begin
    if (GEO_W'(cell_width_q) > GEO_W'(MAX_CELL_WIDTH)) fw = FwW'(MAX_CELL_WIDTH);
    else fw = FwW'(cell_width_q);
    if (GEO_W'(cell_height_q) > GEO_W'(MAX_CELL_HEIGHT)) fh = FhW'(MAX_CELL_HEIGHT);
    else fh = FhW'(cell_height_q);
  end

  // first bar sits at size/2, one less on even sizes; second bar two further on
  always_comb begin
    geo_o.fw   = GEO_W'(fw);
    geo_o.fh   = GEO_W'(fh);
    geo_o.latx = GEO_W'(fw >> 1) - GEO_W'(!fw[0]);
    geo_o.taty = GEO_W'(fh >> 1) - GEO_W'(!fh[0]);
    geo_o.ratx = geo_o.latx + GEO_W'(2);
    geo_o.baty = geo_o.taty + GEO_W'(2);
  end

endmodule

// ===== rtl/bdg_pixel_eval.sv =====
// box drawing glyph generator: one pixel of a glyph as the union of its parts
// depends on bdg_pkg
module bdg_pixel_eval (
  input  bdg_pkg::geo_t    geo_i,
  input  logic [7:0]       char_code_i,
  input  logic [4:0]       column_i,
  input  logic [4:0]       row_i,
  output bdg_pkg::pix_res_t res_o
);
  import bdg_pkg::*;

  logic [GEO_W-1:0] x, y;
  logic             in_cell, code_ok;
  logic [5:0]       idx;
  part_mask_t       m, hit;
  logic             x_eq_l, x_eq_r, x_le_l, x_le_r, x_ge_l, x_ge_r, x_lt_r;
  logic             y_eq_t, y_eq_b, y_le_t, y_le_b, y_ge_t, y_ge_b, y_lt_b;

  assign x = GEO_W'(column_i);
  assign y = GEO_W'(row_i);

  assign code_ok = (char_code_i >= FIRST_CODE) && (char_code_i <= LAST_CODE);
  assign in_cell = (x < geo_i.fw) && (y < geo_i.fh);
  assign idx     = 6'(char_code_i - FIRST_CODE);
  assign m       = code_ok ? GLYPH_PARTS[idx] : '0;

  // inside the cell the first bar position is never negative, so plain compares do
  assign x_eq_l = x == geo_i.latx;
  assign x_eq_r = x == geo_i.ratx;
  assign x_le_l = x <= geo_i.latx;
  assign x_le_r = x <= geo_i.ratx;
  assign x_ge_l = x >= geo_i.latx;
  assign x_ge_r = x >= geo_i.ratx;
  assign x_lt_r = x < geo_i.ratx;
  assign y_eq_t = y == geo_i.taty;
  assign y_eq_b = y == geo_i.baty;
  assign y_le_t = y <= geo_i.taty;
  assign y_le_b = y <= geo_i.baty;
  assign y_ge_t = y >= geo_i.taty;
  assign y_ge_b = y >= geo_i.baty;
  assign y_lt_b = y < geo_i.baty;

  always_comb begin
    hit = '0;
    if ((m & M_FULL) != '0) hit[0]  = 1'b1;
    if ((m & M_TOP)  != '0) hit[1]  = y_lt_b;
    if ((m & M_BOT)  != '0) hit[2]  = y_ge_b;
    if ((m & M_LH)   != '0) hit[3]  = x_lt_r;
    if ((m & M_RH)   != '0) hit[4]  = x_ge_r;
    if ((m & M_V1)   != '0) hit[5]  = x_eq_l;
    if ((m & M_V2)   != '0) hit[6]  = x_eq_r;
    if ((m & M_L1S)  != '0) hit[7]  = x_le_l && y_eq_b;
    if ((m & M_L1L)  != '0) hit[8]  = x_le_r && y_eq_b;
    if ((m & M_L2S)  != '0) hit[9]  = x_le_l && y_eq_t;
    if ((m & M_L2L)  != '0) hit[10] = x_le_r && y_eq_t;
    if ((m & M_R1S)  != '0) hit[11] = x_ge_r && y_eq_b;
    if ((m & M_R1L)  != '0) hit[12] = x_ge_l && y_eq_b;
    if ((m & M_R2S)  != '0) hit[13] = x_ge_r && y_eq_t;
    if ((m & M_R2L)  != '0) hit[14] = x_ge_l && y_eq_t;
    if ((m & M_H1)   != '0) hit[15] = y_eq_b;
    if ((m & M_H2)   != '0) hit[16] = y_eq_t;
    if ((m & M_U1L)  != '0) hit[17] = x_eq_l && y_le_b;
    if ((m & M_U1S)  != '0) hit[18] = x_eq_l && y_le_t;
    if ((m & M_U2L)  != '0) hit[19] = x_eq_r && y_le_b;
    if ((m & M_U2S)  != '0) hit[20] = x_eq_r && y_le_t;
    if ((m & M_D1L)  != '0) hit[21] = x_eq_l && y_ge_t;
    if ((m & M_D1S)  != '0) hit[22] = x_eq_l && y_ge_b;
    if ((m & M_D2L)  != '0) hit[23] = x_eq_r && y_ge_t;
    if ((m & M_D2S)  != '0) hit[24] = x_eq_r && y_ge_b;
  end

  assign res_o.handled  = code_ok;
  assign res_o.pixel_on = code_ok && in_cell && (hit != '0);

endmodule

// ===== rtl/box_drawing_glyph_generator_unit.sv =====
// box drawing glyph generator, top level: input register, glyph evaluation, result register
// a beat moves from the input register to the result register; one beat per cycle sustained
// the rate is set by the single evaluation stage between the two registers
// a stalled output holds the result register; the input register still takes a beat while
// it is empty or the result register is free; reset clears both valid flags and sets
// the cell to 8 by 16; depends on bdg_pkg, bdg_cfg_regs, bdg_pixel_eval
module box_drawing_glyph_generator_unit #(
  parameter int MAX_CELL_WIDTH  = 32,
  parameter int MAX_CELL_HEIGHT = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // apb configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bdg_pkg::ADDR_W-1:0]   paddr,
  input  logic [bdg_pkg::DATA_W-1:0]   pwdata,
  output logic [bdg_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  // input beats
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   char_code_i,
  input  logic [4:0]                   column_i,
  input  logic [4:0]                   row_i,
  // result beats
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         pixel_on_o,
  output logic                         handled_o
);
  import bdg_pkg::*;

  geo_t     geo;
  pix_res_t res;

  // input register
  logic       s1_valid_q;
  logic [7:0] code_q;
  logic [4:0] col_q;
  logic [4:0] row_q;

  // result register
  logic       out_valid_q;
  logic       pixel_on_q;
  logic       handled_q;

  logic out_free, s1_adv, in_acc;

  // cell size registers; geometry follows the registers directly, so an item
  // taken right after a write already sees the new size
  bdg_cfg_regs #(
    .MAX_CELL_WIDTH  (MAX_CELL_WIDTH),
    .MAX_CELL_HEIGHT (MAX_CELL_HEIGHT)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geo_o   (geo)
  );

  // glyph evaluation for the beat in the input register
  bdg_pixel_eval u_eval (
    .geo_i       (geo),
    .char_code_i (code_q),
    .column_i    (col_q),
    .row_i       (row_q),
    .res_o       (res)
  );

  // the result register is free when empty or being drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // input register refills or empties as its beat moves on
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      out_valid_q <= s1_adv || (out_valid_q && out_stall_i);
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      code_q <= char_code_i;
      col_q  <= column_i;
      row_q  <= row_i;
    end
    if (s1_adv) begin
      pixel_on_q <= res.pixel_on;
      handled_q  <= res.handled;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_on_o  = pixel_on_q;
  assign handled_o   = handled_q;

  // a lit pixel always belongs to a handled code
  a_lit_is_handled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_on_o |-> handled_o)
    else $error("lit pixel on an unhandled code");

  // an accepted beat sits in the input register on the next cycle
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> s1_valid_q)
    else $error("accepted beat lost before evaluation");

  // both registers full and output held back means no new beat may enter
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("input taken while pipeline full");

  // a beat in the input register with a free result register moves on
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !(out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("evaluated beat did not reach the result register");

endmodule

// ===== test/tb_glyph_pkg.sv =====
// glyph pixel predictor and scoreboard for the box drawing glyph generator bench
// holds its own part table and cell geometry math; no dependencies
package tb_glyph_pkg;

  localparam int GLYPH_MAX_W = 32;
  localparam int GLYPH_MAX_H = 32;

  localparam bit [7:0] FIRST_GLYPH = 8'd179;
  localparam bit [7:0] LAST_GLYPH  = 8'd223;

  localparam int RESET_WIDTH  = 8;
  localparam int RESET_HEIGHT = 16;

  // rectangles a glyph can be built from
  localparam bit [24:0] PART_FULL  = 25'h1 << 0;
  localparam bit [24:0] PART_UPPER = 25'h1 << 1;
  localparam bit [24:0] PART_LOWER = 25'h1 << 2;
  localparam bit [24:0] PART_LEFT  = 25'h1 << 3;
  localparam bit [24:0] PART_RIGHT = 25'h1 << 4;
  localparam bit [24:0] PART_VBAR1 = 25'h1 << 5;
  localparam bit [24:0] PART_VBAR2 = 25'h1 << 6;
  localparam bit [24:0] PART_W1S   = 25'h1 << 7;
  localparam bit [24:0] PART_W1L   = 25'h1 << 8;
  localparam bit [24:0] PART_W2S   = 25'h1 << 9;
  localparam bit [24:0] PART_W2L   = 25'h1 << 10;
  localparam bit [24:0] PART_E1S   = 25'h1 << 11;
  localparam bit [24:0] PART_E1L   = 25'h1 << 12;
  localparam bit [24:0] PART_E2S   = 25'h1 << 13;
  localparam bit [24:0] PART_E2L   = 25'h1 << 14;
  localparam bit [24:0] PART_HBAR1 = 25'h1 << 15;
  localparam bit [24:0] PART_HBAR2 = 25'h1 << 16;
  localparam bit [24:0] PART_N1L   = 25'h1 << 17;
  localparam bit [24:0] PART_N1S   = 25'h1 << 18;
  localparam bit [24:0] PART_N2L   = 25'h1 << 19;
  localparam bit [24:0] PART_N2S   = 25'h1 << 20;
  localparam bit [24:0] PART_S1L   = 25'h1 << 21;
  localparam bit [24:0] PART_S1S   = 25'h1 << 22;
  localparam bit [24:0] PART_S2L   = 25'h1 << 23;
  localparam bit [24:0] PART_S2S   = 25'h1 << 24;

  typedef struct {
    bit [7:0] code;
    int       column;
    int       row;
    bit       pixel_on;
    bit       handled;
  } glyph_pixel_t;

  function automatic bit in_box(input int x, y, ax, ay, nx, ny);
    return x >= ax && x < ax + nx && y >= ay && y < ay + ny;
  endfunction

  function automatic bit [24:0] glyph_mask(input bit [7:0] code);
    case (code)
      8'd179: return PART_VBAR1;
      8'd180: return PART_VBAR1 | PART_W1S;
      8'd181: return PART_VBAR1 | PART_W1S | PART_W2S;
      8'd182: return PART_VBAR1 | PART_VBAR2 | PART_W1S;
      8'd183: return PART_W1L | PART_S1S | PART_S2S;
      8'd184: return PART_W1S | PART_W2S | PART_S1L;
      8'd185: return PART_VBAR1 | PART_VBAR2 | PART_W1S | PART_W2S;
      8'd186: return PART_VBAR1 | PART_VBAR2;
      8'd187: return PART_W1S | PART_W2L | PART_S1S | PART_S2L;
      8'd188: return PART_W1L | PART_W2S | PART_N1S | PART_N2L;
      8'd189: return PART_W1L | PART_N1L | PART_N2L;
      8'd190: return PART_W1S | PART_W2S | PART_N1L;
      8'd191: return PART_W1S | PART_S1S;
      8'd192: return PART_E1L | PART_N1L;
      8'd193: return PART_HBAR1 | PART_N1L;
      8'd194: return PART_HBAR1 | PART_S1S;
      8'd195: return PART_VBAR1 | PART_E1L;
      8'd196: return PART_HBAR1;
      8'd197: return PART_VBAR1 | PART_HBAR1;
      8'd198: return PART_VBAR1 | PART_E1L | PART_E2L;
      8'd199: return PART_VBAR1 | PART_VBAR2 | PART_E1S;
      8'd200: return PART_E1L | PART_E2S | PART_N1L | PART_N2S;
      8'd201: return PART_E1S | PART_E2L | PART_S1L | PART_S2S;
      8'd202: return PART_W2S | PART_E2S | PART_HBAR1 | PART_N1S | PART_N2S;
      8'd203: return PART_W1S | PART_E1S | PART_HBAR2 | PART_S1S | PART_S2S;
      8'd204: return PART_VBAR1 | PART_E1S | PART_E2S | PART_N2S | PART_S2S;
      8'd205: return PART_HBAR1 | PART_HBAR2;
      8'd206: return PART_VBAR1 | PART_VBAR2 | PART_W1S | PART_W2S | PART_E1S | PART_E2S
                     | PART_N1S | PART_N2S | PART_S1S | PART_S2S;
      8'd207: return PART_HBAR1 | PART_HBAR2 | PART_N1S;
      8'd208: return PART_W1L | PART_N1L | PART_N2L | PART_HBAR1;
      8'd209: return PART_HBAR1 | PART_HBAR2 | PART_S1S;
      8'd210: return PART_W1L | PART_S1S | PART_S2S | PART_HBAR1;
      8'd211: return PART_E1L | PART_N1L | PART_N2L;
      8'd212: return PART_E1L | PART_E2L | PART_N1L;
      8'd213: return PART_E1L | PART_E2L | PART_S1L;
      8'd214: return PART_E1L | PART_S1S | PART_S2S;
      8'd215: return PART_VBAR1 | PART_VBAR2 | PART_W1S | PART_HBAR1;
      8'd216: return PART_VBAR1 | PART_HBAR1 | PART_HBAR2;
      8'd217: return PART_W1S | PART_N1L;
      8'd218: return PART_E1L | PART_S1S;
      8'd219: return PART_FULL;
      8'd220: return PART_LOWER;
      8'd221: return PART_LEFT;
      8'd222: return PART_RIGHT;
      8'd223: return PART_UPPER;
      default: return '0;
    endcase
  endfunction

  class glyph_scoreboard;
    int unsigned  cell_w;
    int unsigned  cell_h;
    int unsigned  errors;
    glyph_pixel_t pixel_q[$];

    function new();
      cell_w = RESET_WIDTH;
      cell_h = RESET_HEIGHT;
      errors = 0;
    endfunction

    function void set_cell(input int unsigned w, h);
      cell_w = w;
      cell_h = h;
    endfunction

    // expected pixel for one code and position under the current cell size
    function glyph_pixel_t glyph_pixel(input bit [7:0] code, input int x, y);
      glyph_pixel_t p;
      int        fw, fh, latx, ratx, taty, baty, rnbx, lnbx, bnby, tnby;
      bit [24:0] m;
      bit        lit;
      p.code = code;
      p.column = x;
      p.row = y;
      p.pixel_on = 1'b0;
      p.handled = 1'b0;
      if (code < FIRST_GLYPH || code > LAST_GLYPH) return p;
      p.handled = 1'b1;
      fw = (cell_w > GLYPH_MAX_W) ? GLYPH_MAX_W : int'(cell_w);
      fh = (cell_h > GLYPH_MAX_H) ? GLYPH_MAX_H : int'(cell_h);
      if (x >= fw || y >= fh) return p;
      latx = fw / 2 - ((fw % 2 == 0) ? 1 : 0);
      taty = fh / 2 - ((fh % 2 == 0) ? 1 : 0);
      ratx = latx + 2;
      baty = taty + 2;
      rnbx = fw - ratx;
      lnbx = fw - latx;
      bnby = fh - baty;
      tnby = fh - taty;
      m = glyph_mask(code);
      lit = 1'b0;
      if ((m & PART_FULL)  != 0 && in_box(x, y, 0, 0, fw, fh))            lit = 1'b1;
      if ((m & PART_UPPER) != 0 && in_box(x, y, 0, 0, fw, baty))          lit = 1'b1;
      if ((m & PART_LOWER) != 0 && in_box(x, y, 0, baty, fw, bnby))       lit = 1'b1;
      if ((m & PART_LEFT)  != 0 && in_box(x, y, 0, 0, ratx, fh))          lit = 1'b1;
      if ((m & PART_RIGHT) != 0 && in_box(x, y, ratx, 0, rnbx, fh))       lit = 1'b1;
      if ((m & PART_VBAR1) != 0 && in_box(x, y, latx, 0, 1, fh))          lit = 1'b1;
      if ((m & PART_VBAR2) != 0 && in_box(x, y, ratx, 0, 1, fh))          lit = 1'b1;
      if ((m & PART_W1S)   != 0 && in_box(x, y, 0, baty, latx + 1, 1))    lit = 1'b1;
      if ((m & PART_W1L)   != 0 && in_box(x, y, 0, baty, ratx + 1, 1))    lit = 1'b1;
      if ((m & PART_W2S)   != 0 && in_box(x, y, 0, taty, latx + 1, 1))    lit = 1'b1;
      if ((m & PART_W2L)   != 0 && in_box(x, y, 0, taty, ratx + 1, 1))    lit = 1'b1;
      if ((m & PART_E1S)   != 0 && in_box(x, y, ratx, baty, rnbx, 1))     lit = 1'b1;
      if ((m & PART_E1L)   != 0 && in_box(x, y, latx, baty, lnbx, 1))     lit = 1'b1;
      if ((m & PART_E2S)   != 0 && in_box(x, y, ratx, taty, rnbx, 1))     lit = 1'b1;
      if ((m & PART_E2L)   != 0 && in_box(x, y, latx, taty, lnbx, 1))     lit = 1'b1;
      if ((m & PART_HBAR1) != 0 && in_box(x, y, 0, baty, fw, 1))          lit = 1'b1;
      if ((m & PART_HBAR2) != 0 && in_box(x, y, 0, taty, fw, 1))          lit = 1'b1;
      if ((m & PART_N1L)   != 0 && in_box(x, y, latx, 0, 1, baty + 1))    lit = 1'b1;
      if ((m & PART_N1S)   != 0 && in_box(x, y, latx, 0, 1, taty + 1))    lit = 1'b1;
      if ((m & PART_N2L)   != 0 && in_box(x, y, ratx, 0, 1, baty + 1))    lit = 1'b1;
      if ((m & PART_N2S)   != 0 && in_box(x, y, ratx, 0, 1, taty + 1))    lit = 1'b1;
      if ((m & PART_S1L)   != 0 && in_box(x, y, latx, taty, 1, tnby))     lit = 1'b1;
      if ((m & PART_S1S)   != 0 && in_box(x, y, latx, baty, 1, bnby))     lit = 1'b1;
      if ((m & PART_S2L)   != 0 && in_box(x, y, ratx, taty, 1, tnby))     lit = 1'b1;
      if ((m & PART_S2S)   != 0 && in_box(x, y, ratx, baty, 1, bnby))     lit = 1'b1;
      p.pixel_on = lit;
      return p;
    endfunction

    function void accept_pixel(input bit [7:0] code, input int x, y);
      pixel_q.push_back(glyph_pixel(code, x, y));
    endfunction

    function void check_pixel(input logic pixel_on, handled);
      glyph_pixel_t e;
      if (pixel_q.size() == 0) begin
        $error("result beat with no pixel waiting: pixel_on %0b handled %0b", pixel_on, handled);
        errors++;
        return;
      end
      e = pixel_q.pop_front();
      if (handled !== e.handled) begin
        $error("handled mismatch, code %0d at (%0d,%0d): expected %0b, actual %0b",
               e.code, e.column, e.row, e.handled, handled);
        errors++;
      end
      if (pixel_on !== e.pixel_on) begin
        $error("pixel_on mismatch, code %0d at (%0d,%0d): expected %0b, actual %0b",
               e.code, e.column, e.row, e.pixel_on, pixel_on);
        errors++;
      end
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction
  endclass

endpackage

// ===== test/tb_top.sv =====
// top of the box drawing glyph generator bench: clock, reset, apb setup, beat drivers,
// monitor and watchdog; depends on bdg_pkg, tb_glyph_pkg and the generator rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tb_glyph_pkg::*;

  localparam int RESET_CYCLES    = 12;
  localparam int SETTLE_CYCLES   = 4;    // result path is two stages deep
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 156;

  localparam logic [bdg_pkg::ADDR_W-1:0] ADDR_CELL_WIDTH  = 3'd0;
  localparam logic [bdg_pkg::ADDR_W-1:0] ADDR_CELL_HEIGHT = 3'd4;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [bdg_pkg::ADDR_W-1:0]   paddr = '0;
  logic [bdg_pkg::DATA_W-1:0]   pwdata = '0;
  logic [bdg_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [7:0]                   char_code_i = '0;
  logic [4:0]                   column_i = '0;
  logic [4:0]                   row_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic                         pixel_on_o;
  logic                         handled_o;

  // percentages of cycles in which the sender holds back and the receiver stalls
  int unsigned send_idle_pct = 38;
  int unsigned recv_stall_pct = 87;

  glyph_scoreboard sb = new();

  box_drawing_glyph_generator_unit #(
    .MAX_CELL_WIDTH (GLYPH_MAX_W),
    .MAX_CELL_HEIGHT(GLYPH_MAX_H)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .char_code_i(char_code_i),
    .column_i   (column_i),
    .row_i      (row_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .pixel_on_o (pixel_on_o),
    .handled_o  (handled_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // receiver back-pressure, redrawn every falling edge
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // monitor: results are checked before the same edge's input beat is noted,
  // an input beat can never come out at the edge it goes in
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_pixel(pixel_on_o, handled_o);
      if (in_valid_i && !in_stall_o) sb.accept_pixel(char_code_i, int'(column_i), int'(row_i));
    end
  end

  // watchdog: ends the run after a long stretch with no beat on either side
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // one apb transfer, setup then access; entered and left at a falling edge
  task automatic apb_access(input bit wr, input logic [bdg_pkg::ADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // present one input beat and hold it until taken; valid stays high on return
  // so a back-to-back beat never drops it
  task automatic send_pixel(input logic [7:0] code, input logic [4:0] col, row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    char_code_i = code;
    column_i = col;
    row_i = row;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // stop sending and wait for every pending pixel to come back
  task automatic wait_results_drained();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // coordinate inside the cell, often near the bars, now and then anywhere in range
  function automatic logic [4:0] pick_coord(input int unsigned size);
    int span, lat, lo, hi;
    span = (size > 32) ? 32 : int'(size);
    if (span == 0 || $urandom_range(9) == 0) return 5'($urandom_range(31));
    lat = span / 2 - ((span % 2 == 0) ? 1 : 0);
    if ($urandom_range(2) == 0) begin
      lo = (lat > 0) ? lat - 1 : 0;
      hi = (lat + 3 < span - 1) ? lat + 3 : span - 1;
      return 5'($urandom_range(hi, lo));
    end
    return 5'($urandom_range(span - 1, 0));
  endfunction

  initial begin : stimulus
    int unsigned phase_w [NUM_PHASES] = '{4, 32, 63, 0, 5, 1, 3, 33, 17, 16, 2, 31};
    int unsigned phase_h [NUM_PHASES] = '{4, 32, 63, 0, 7, 2, 3, 40, 25, 9, 31, 4};
    int unsigned cw, ch;
    logic [31:0] rd, dummy;
    logic [7:0]  code;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed beats on the reset cell of 8 by 16: bars at columns 3 and 5, rows 7 and 9
    send_pixel(8'd0, 5'd0, 5'd0);        // codes outside the semigraphic range
    send_pixel(8'd255, 5'd31, 5'd31);
    send_pixel(8'd178, 5'd3, 5'd9);
    send_pixel(8'd224, 5'd3, 5'd9);
    send_pixel(8'd179, 5'd3, 5'd0);      // first handled code
    send_pixel(8'd179, 5'd31, 5'd31);    // handled but outside the cell
    send_pixel(8'd223, 5'd0, 5'd8);      // last code, upper block edge
    send_pixel(8'd223, 5'd0, 5'd9);
    send_pixel(8'd219, 5'd7, 5'd15);     // full block corner and just past it
    send_pixel(8'd219, 5'd8, 5'd0);
    send_pixel(8'd219, 5'd0, 5'd16);
    send_pixel(8'd199, 5'd7, 5'd9);      // right stub on the lower row
    send_pixel(8'd199, 5'd4, 5'd9);
    send_pixel(8'd208, 5'd0, 5'd9);      // full lower bar on an up-tee and a down-tee variant
    send_pixel(8'd208, 5'd7, 5'd9);
    send_pixel(8'd210, 5'd0, 5'd9);
    send_pixel(8'd210, 5'd7, 5'd9);
    send_pixel(8'd220, 5'd0, 5'd9);      // half blocks on both sides of their split
    send_pixel(8'd220, 5'd0, 5'd8);
    send_pixel(8'd221, 5'd4, 5'd0);
    send_pixel(8'd221, 5'd5, 5'd0);
    send_pixel(8'd222, 5'd5, 5'd0);
    send_pixel(8'd222, 5'd4, 5'd0);
    send_pixel(8'd206, 5'd3, 5'd9);      // double cross
    send_pixel(8'd206, 5'd4, 5'd8);

    for (int p = 0; p < NUM_PHASES; p++) begin
      cw = phase_w[p];
      ch = phase_h[p];
      if (p == 8 || p == 9) begin
        cw = $urandom_range(63);
        ch = $urandom_range(63);
      end

      // reprogram the cell only with the pipeline empty
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(negedge clk_i);
      apb_access(1'b1, ADDR_CELL_WIDTH, 32'(cw), dummy);
      apb_access(1'b1, ADDR_CELL_HEIGHT, 32'(ch), dummy);
      apb_access(1'b0, ADDR_CELL_WIDTH, '0, rd);
      if (rd !== 32'(cw)) begin
        $error("cell_width readback mismatch: expected %0d, actual %0d", cw, rd);
        sb.errors++;
      end
      apb_access(1'b0, ADDR_CELL_HEIGHT, '0, rd);
      if (rd !== 32'(ch)) begin
        $error("cell_height readback mismatch: expected %0d, actual %0d", ch, rd);
        sb.errors++;
      end
      sb.set_cell(cw, ch);

      // slow receiver first, then slow sender, then full rate
      if (p < 4) begin
        send_idle_pct = 38;
        recv_stall_pct = 87;
      end else if (p < 8) begin
        send_idle_pct = 87;
        recv_stall_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // let the pipeline run dry once in the middle of a phase
        if (p == 6 && n == ITEMS_PER_PHASE / 2) wait_results_drained();
        if ($urandom_range(9) < 8) code = 8'($urandom_range(LAST_GLYPH, FIRST_GLYPH));
        else code = 8'($urandom_range(255));
        send_pixel(code, pick_coord(cw), pick_coord(ch));
      end
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bdg_pkg.sv
rtl/bdg_cfg_regs.sv
rtl/bdg_pixel_eval.sv
rtl/box_drawing_glyph_generator_unit.sv
test/tb_glyph_pkg.sv
test/tb_top.sv
